FILE: hdl/assert_macros.svh
// assertion macros for the evaluator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/crp_pkg.sv
// types, constants and helpers for the catmull-rom point evaluator
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

    localparam int COORD_W = 32;
    localparam int PARAM_W = 17;
    localparam int CNT_W   = 3;

    // exact widths of the doubled basis coefficients and the accumulator
    localparam int D1_W  = COORD_W + 1;
    localparam int D2_W  = COORD_W + 4;
    localparam int D3_W  = COORD_W + 3;
    localparam int D3X_W = D3_W + 2;
    localparam int ACC_W = COORD_W + 8;

    localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(4);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [PARAM_W-1:0]        t_param;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    function automatic t_coord sat_acc(input logic signed [ACC_W-1:0] v);
        logic   ovf;
        t_coord res;
        ovf = (v[ACC_W-1:COORD_W-1] != '0) && (v[ACC_W-1:COORD_W-1] != '1);
        if (!ovf) begin
            res = v[COORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/crp_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface crp_req_if;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic signed [31:0]     coord_x;
    logic signed [31:0]     coord_y;
    logic signed [31:0]     coord_z;
    logic [16:0]            param_u;

    modport source (output valid, req_type, coord_x, coord_y, coord_z, param_u,
                    input ready);
    modport sink   (input valid, req_type, coord_x, coord_y, coord_z, param_u,
                    output ready);
endinterface

interface crp_res_if;
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     pos_x;
    logic signed [31:0]     pos_y;
    logic signed [31:0]     pos_z;
    logic signed [31:0]     slope_x;
    logic signed [31:0]     slope_y;
    logic signed [31:0]     slope_z;
    logic                   not_ready;

    modport source (output valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                    not_ready, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                    not_ready, output ready);
endinterface

`default_nettype wire

FILE: hdl/crp_axis.sv
// five-stage datapath for one coordinate axis
`timescale 1ns / 1ps
`default_nettype none

module crp_axis #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire crp_pkg::t_pipe_en i_en,
    input  wire crp_pkg::t_coord   i_p0,
    input  wire crp_pkg::t_coord   i_p1,
    input  wire crp_pkg::t_coord   i_p2,
    input  wire crp_pkg::t_coord   i_p3,
    input  wire logic [FRAC_BITS:0] i_u_s1,
    input  wire logic [FRAC_BITS:0] i_u2_s2,
    input  wire logic [FRAC_BITS:0] i_u3_s3,
    input  wire logic              i_nr_s4,
    output crp_pkg::t_coord        o_pos,
    output crp_pkg::t_coord        o_slope
);
    import crp_pkg::*;

    localparam int UW   = FRAC_BITS + 1;
    localparam int P1W  = D1_W + UW + 1;
    localparam int P2W  = D2_W + UW + 1;
    localparam int P3XW = D3X_W + UW + 1;
    localparam int P3W  = D3_W + UW + 1;

    logic signed [D2_W-1:0]  e0, e1, e2, e3;
    logic signed [D3_W-1:0]  f0, f1, f2, f3;

    logic signed [D1_W-1:0]  n_d1;
    logic signed [D2_W-1:0]  n_d2;
    logic signed [D3_W-1:0]  n_d3;
    logic signed [P1W-1:0]   n_d1u;
    logic signed [P2W-1:0]   n_d2u;
    logic signed [D3X_W-1:0] n_d3x3;
    logic signed [P2W-1:0]   n_d2u2;
    logic signed [P3XW-1:0]  n_d3x3u2;
    logic signed [P3W-1:0]   n_d3u3;
    logic signed [ACC_W-1:0] n_pos_s4;
    logic signed [ACC_W-1:0] n_slope_s4;
    logic signed [ACC_W-1:0] n_pos_acc;
    t_coord                  n_pos;
    t_coord                  n_slope;

    // stage 1
    logic signed [D1_W-1:0]  r_d1_s1;
    logic signed [D2_W-1:0]  r_d2_s1;
    logic signed [D3_W-1:0]  r_d3_s1;
    t_coord                  r_p1_s1;
    // stage 2
    logic signed [D1_W-1:0]  r_d1_s2;
    logic signed [D2_W-1:0]  r_d2_s2;
    logic signed [D3_W-1:0]  r_d3_s2;
    logic signed [D3X_W-1:0] r_d3x3_s2;
    logic signed [P1W-1:0]   r_d1u_s2;
    logic signed [P2W-1:0]   r_d2u_s2;
    t_coord                  r_p1_s2;
    // stage 3
    logic signed [D1_W-1:0]  r_d1_s3;
    logic signed [D3_W-1:0]  r_d3_s3;
    logic signed [P1W-1:0]   r_d1u_s3;
    logic signed [P2W-1:0]   r_d2u_s3;
    logic signed [P2W-1:0]   r_d2u2_s3;
    logic signed [P3XW-1:0]  r_d3x3u2_s3;
    t_coord                  r_p1_s3;
    // stage 4
    logic signed [ACC_W-1:0] r_pos_s4;
    logic signed [ACC_W-1:0] r_slope_s4;
    logic signed [P3W-1:0]   r_d3u3_s4;
    // stage 5
    t_coord                  r_pos_s5;
    t_coord                  r_slope_s5;

    always_comb begin
        e0 = D2_W'(i_p0);
        e1 = D2_W'(i_p1);
        e2 = D2_W'(i_p2);
        e3 = D2_W'(i_p3);
        f0 = D3_W'(i_p0);
        f1 = D3_W'(i_p1);
        f2 = D3_W'(i_p2);
        f3 = D3_W'(i_p3);

        // doubled basis coefficients, kept exact
        n_d1 = D1_W'(i_p2) - D1_W'(i_p0);
        n_d2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        n_d3 = f3 - f0 + (f1 <<< 1) + f1 - (f2 <<< 1) - f2;

        n_d1u  = P1W'(r_d1_s1) * P1W'($signed({1'b0, i_u_s1}));
        n_d2u  = P2W'(r_d2_s1) * P2W'($signed({1'b0, i_u_s1}));
        n_d3x3 = (D3X_W'(r_d3_s1) <<< 1) + D3X_W'(r_d3_s1);

        n_d2u2   = P2W'(r_d2_s2) * P2W'($signed({1'b0, i_u2_s2}));
        n_d3x3u2 = P3XW'(r_d3x3_s2) * P3XW'($signed({1'b0, i_u2_s2}));

        n_d3u3     = P3W'(r_d3_s3) * P3W'($signed({1'b0, i_u3_s3}));
        n_pos_s4   = ACC_W'(r_p1_s3)
                   + ACC_W'($signed(r_d1u_s3[P1W-1:FRAC_BITS+1]))
                   + ACC_W'($signed(r_d2u2_s3[P2W-1:FRAC_BITS+1]));
        n_slope_s4 = ACC_W'($signed(r_d1_s3[D1_W-1:1]))
                   + ACC_W'($signed(r_d2u_s3[P2W-1:FRAC_BITS]))
                   + ACC_W'($signed(r_d3x3u2_s3[P3XW-1:FRAC_BITS+1]));

        n_pos_acc = r_pos_s4 + ACC_W'($signed(r_d3u3_s4[P3W-1:FRAC_BITS+1]));
        n_pos     = i_nr_s4 ? '0 : sat_acc(n_pos_acc);
        n_slope   = i_nr_s4 ? '0 : sat_acc(r_slope_s4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_d1_s1 <= n_d1;
            r_d2_s1 <= n_d2;
            r_d3_s1 <= n_d3;
            r_p1_s1 <= i_p1;
        end
        if (i_en.s2) begin
            r_d1_s2   <= r_d1_s1;
            r_d2_s2   <= r_d2_s1;
            r_d3_s2   <= r_d3_s1;
            r_d3x3_s2 <= n_d3x3;
            r_d1u_s2  <= n_d1u;
            r_d2u_s2  <= n_d2u;
            r_p1_s2   <= r_p1_s1;
        end
        if (i_en.s3) begin
            r_d1_s3     <= r_d1_s2;
            r_d3_s3     <= r_d3_s2;
            r_d1u_s3    <= r_d1u_s2;
            r_d2u_s3    <= r_d2u_s2;
            r_d2u2_s3   <= n_d2u2;
            r_d3x3u2_s3 <= n_d3x3u2;
            r_p1_s3     <= r_p1_s2;
        end
        if (i_en.s4) begin
            r_pos_s4   <= n_pos_s4;
            r_slope_s4 <= n_slope_s4;
            r_d3u3_s4  <= n_d3u3;
        end
        if (i_en.s5) begin
            r_pos_s5   <= n_pos;
            r_slope_s5 <= n_slope;
        end
    end

    assign o_pos   = r_pos_s5;
    assign o_slope = r_slope_s5;

endmodule

`default_nettype wire

FILE: hdl/catmull_rom_point_evaluator_top.sv
// top level of the catmull-rom point evaluator: point window, parameter powers, control
//
//  channel | direction | payload
//  i_req   | in        | req_type, coord_x/y/z, param_u
//  o_res   | out       | pos_x/y/z, slope_x/y/z, not_ready
//
// one item per cycle while the output is not stalled; an evaluate passes stages s1 to s5 before o_res shows its result
// its path runs through the multiply chain u -> u^2 -> u^3 -> d3*u^3 and the final sum
// a push updates the window at its transfer and gives no result
// reset clears the point count and stage valid bits, not the window contents
// each stage holds while full and the next cannot take, so a stalled output fills the bubbles first
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module catmull_rom_point_evaluator_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    crp_req_if.sink    i_req,
    crp_res_if.source  o_res
);
    import crp_pkg::*;

    localparam int UW  = FRAC_BITS + 1;
    localparam int CW  = (PARAM_W > UW) ? PARAM_W : UW;
    localparam int SQW = 2 * UW;
    localparam logic [CW-1:0] U_ONE = CW'(1) << FRAC_BITS;

    t_coord           r_win [0:3][0:2];
    logic [CNT_W-1:0] r_count;

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic             r_nr1, r_nr2, r_nr3, r_nr4, r_nr5;
    logic [UW-1:0]    r_u_s1, r_u_s2, r_u2_s2, r_u3_s3;

    logic             w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic             w_acc;
    logic             w_is_eval;
    t_pipe_en         w_en;
    logic [CW-1:0]    w_u_ext;
    logic [UW-1:0]    n_u;
    logic [SQW-1:0]   w_sq;
    logic [SQW-1:0]   w_cube;
    t_coord           w_pos   [0:2];
    t_coord           w_slope [0:2];

    assign w_rdy5 = !r_v5 || o_res.ready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_en = '{s1: w_rdy1, s2: w_rdy2, s3: w_rdy3, s4: w_rdy4, s5: w_rdy5};

    assign i_req.ready = w_rdy1;
    assign w_acc       = i_req.valid && w_rdy1;
    assign w_is_eval   = (i_req.req_type == REQ_EVAL);

    // parameter clamped to one, then its square and cube
    assign w_u_ext = CW'(i_req.param_u);
    assign n_u     = (w_u_ext > U_ONE) ? U_ONE[UW-1:0] : w_u_ext[UW-1:0];
    assign w_sq    = SQW'(r_u_s1) * SQW'(r_u_s1);
    assign w_cube  = SQW'(r_u2_s2) * SQW'(r_u_s2);

    // point window and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc && !w_is_eval && (r_count != MAX_POINTS)) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_is_eval) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2]    <= r_win[3];
            r_win[3][0] <= i_req.coord_x;
            r_win[3][1] <= i_req.coord_y;
            r_win[3][2] <= i_req.coord_z;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en.s1) r_v1 <= w_acc && w_is_eval;
            if (w_en.s2) r_v2 <= r_v1;
            if (w_en.s3) r_v3 <= r_v2;
            if (w_en.s4) r_v4 <= r_v3;
            if (w_en.s5) r_v5 <= r_v4;
        end
    end

    // shared parameter path and not-ready flag
    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r_u_s1 <= n_u;
            r_nr1  <= (r_count != MAX_POINTS);
        end
        if (w_en.s2) begin
            r_u_s2  <= r_u_s1;
            r_u2_s2 <= w_sq[2*FRAC_BITS:FRAC_BITS];
            r_nr2   <= r_nr1;
        end
        if (w_en.s3) begin
            r_u3_s3 <= w_cube[2*FRAC_BITS:FRAC_BITS];
            r_nr3   <= r_nr2;
        end
        if (w_en.s4) r_nr4 <= r_nr3;
        if (w_en.s5) r_nr5 <= r_nr4;
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        crp_axis #(
            .FRAC_BITS (FRAC_BITS)
        ) u_axis (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_p0    (r_win[0][a]),
            .i_p1    (r_win[1][a]),
            .i_p2    (r_win[2][a]),
            .i_p3    (r_win[3][a]),
            .i_u_s1  (r_u_s1),
            .i_u2_s2 (r_u2_s2),
            .i_u3_s3 (r_u3_s3),
            .i_nr_s4 (r_nr4),
            .o_pos   (w_pos[a]),
            .o_slope (w_slope[a])
        );
    end

    assign o_res.valid     = r_v5;
    assign o_res.pos_x     = w_pos[0];
    assign o_res.pos_y     = w_pos[1];
    assign o_res.pos_z     = w_pos[2];
    assign o_res.slope_x   = w_slope[0];
    assign o_res.slope_y   = w_slope[1];
    assign o_res.slope_z   = w_slope[2];
    assign o_res.not_ready = r_nr5;

    `ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= MAX_POINTS)
    `ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_acc && !w_is_eval && (r_count != MAX_POINTS), r_count == $past(r_count) + CNT_W'(1))
    `ASSERT_NEXT(a_eval_enters, i_clk, i_rst_n, w_acc && w_is_eval, r_v1)
    `ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_v3 && !w_rdy3, r_v3)
    `ASSERT_IMPL(a_nr_zero, i_clk, i_rst_n, r_v5 && r_nr5, (w_pos[0] == '0) && (w_slope[2] == '0))

endmodule

`default_nettype wire
